FILE: sv/ese_pkg.sv
// Shared types and constants for the encoder speed estimator.
// No dependencies; used by ese_divider and encoder_speed_estimator_unit.
package ese_pkg;

  localparam int CHANNELS_DEF = 4;

  // Numerator: |delta| (<= 32768) times the Q8 scale, below 2^38.
  localparam int NUM_W = 38;
  // Denominator: 32-bit interval times 16-bit pulses per rev.
  localparam int DEN_W = 48;

  // 60000 / 4 * 256
  localparam logic [21:0] SCALE_Q8 = 22'd3840000;

  localparam logic [15:0] PPR_RESET = 16'd330;

  localparam logic CMD_MEASURE  = 1'b0;
  localparam logic CMD_BASELINE = 1'b1;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_BAD_CHAN  = 2'd1;
  localparam logic [1:0] ST_ZERO_DT   = 2'd2;
  localparam logic [1:0] ST_BASELINE  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: sv/ese_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ese_pkg for the request and response structs.
module ese_divider #(
  parameter int NumW = ese_pkg::NUM_W,
  parameter int DenW = ese_pkg::DEN_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ese_pkg::div_req_t req_i,
  output ese_pkg::div_rsp_t rsp_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [DenW-1:0] rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DenW:0]   trial;
  logic [DenW+1:0] sub;
  logic            ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign sub   = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~sub[DenW+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? sub[DenW-1:0] : trial[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with no steps left");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |=> !done_q)
    else $error("divider done too early");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$past(req_i.start) && den_q != '0) |-> rem_q < den_q)
    else $error("partial remainder not below divisor");

endmodule

FILE: sv/encoder_speed_estimator_unit.sv
// Encoder speed estimator top level: channel baseline store, sequencer,
// operand multipliers and output register. Uses ese_pkg and ese_divider.
//
// Channel   Handshake              Payload
// in        in_valid_i/in_stall_o  command_i, channel_i, encoder_count_i, tick_ms_i
// out       out_valid_o/out_stall_i rpm_q8_o, status_o
// cfg       cfg_valid_i/cfg_ready_o cfg_data_i (pulses per rev)
//
// A measure with a nonzero interval reads and updates the baseline on the
// accepting edge, then forms the operands in S_MUL, runs 38 steps of the shared
// restoring divider in S_DIV, saturates the quotient into the result register
// and loads the output register from S_FIN. The next transaction is taken once
// the sequencer is back in S_IDLE. Bad channel, baseline load and zero interval
// results go from accept straight to S_FIN and then to the output register.
// Reset clears all baselines to zero and pulses per rev to 330.
// A stalled output holds the sequencer in its last state; input is stalled
// whenever an item is in flight.
module encoder_speed_estimator_unit #(
  parameter int CHANNELS = ese_pkg::CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [2:0]         channel_i,
  input  logic [15:0]        encoder_count_i,
  input  logic [31:0]        tick_ms_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] rpm_q8_o,
  output logic [1:0]         status_o
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] ChanLimit = 4'(CHANNELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int NumW = ese_pkg::NUM_W;
  localparam int DenW = ese_pkg::DEN_W;

  logic [1:0]  state_q, state_d;
  logic [15:0] ppr_q;

  logic [15:0] prev_count_q [CHANNELS];
  logic [31:0] prev_tick_q  [CHANNELS];

  logic [15:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [31:0] dt_q, dt_d;
  logic [31:0] res_rpm_q, res_rpm_d;
  logic [1:0]  res_status_q, res_status_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rpm_q;
  logic [1:0]  out_status_q;

  logic            in_acc;
  logic            bad_chan;
  logic [IdxW-1:0] idx;
  logic            store_we;
  logic [15:0]     diff16;
  logic [31:0]     dt_now;
  logic            out_load;
  logic [15:0]     ppr_eff;
  logic [31:0]     q_sat;

  ese_pkg::div_req_t div_req;
  ese_pkg::div_rsp_t div_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= ese_pkg::PPR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ppr_q <= cfg_data_i;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign bad_chan   = ({1'b0, channel_i} >= ChanLimit);
  assign idx        = channel_i[IdxW-1:0];
  assign store_we   = in_acc && !bad_chan;
  assign diff16     = encoder_count_i - prev_count_q[idx];
  assign dt_now     = tick_ms_i - prev_tick_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_count_q[i] <= '0;
        prev_tick_q[i]  <= '0;
      end
    end else if (store_we) begin
      prev_count_q[idx] <= encoder_count_i;
      prev_tick_q[idx]  <= tick_ms_i;
    end
  end

  assign ppr_eff = (ppr_q == 16'd0) ? 16'd1 : ppr_q;

  // Operands go straight into the divider's registers.
  always_comb begin
    div_req.start = (state_q == S_MUL);
    div_req.num   = {22'b0, mag_q} * {16'b0, ese_pkg::SCALE_Q8};
    div_req.den   = {16'b0, dt_q} * {32'b0, ppr_eff};
  end

  ese_divider #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Saturate the magnitude: 2^31 allowed when negative, 2^31-1 otherwise.
  always_comb begin
    if (neg_q) begin
      q_sat = (div_rsp.quo > NumW'(32'h8000_0000)) ? 32'h8000_0000 : div_rsp.quo[31:0];
    end else begin
      q_sat = (div_rsp.quo > NumW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_rsp.quo[31:0];
    end
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    dt_d         = dt_q;
    res_rpm_d    = res_rpm_q;
    res_status_d = res_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_rpm_d = '0;
          state_d   = S_FIN;
          if (bad_chan) begin
            res_status_d = ese_pkg::ST_BAD_CHAN;
          end else if (command_i == ese_pkg::CMD_BASELINE) begin
            res_status_d = ese_pkg::ST_BASELINE;
          end else if (dt_now == 32'd0) begin
            res_status_d = ese_pkg::ST_ZERO_DT;
          end else begin
            res_status_d = ese_pkg::ST_VALID;
            neg_d        = diff16[15];
            mag_d        = diff16[15] ? (16'd0 - diff16) : diff16;
            dt_d         = dt_now;
            state_d      = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_rpm_d = neg_q ? (32'd0 - q_sat) : q_sat;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_FIN && out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    dt_q         <= dt_d;
    res_rpm_q    <= res_rpm_d;
    res_status_q <= res_status_d;
    if (state_q == S_FIN && out_load) begin
      out_rpm_q    <= res_rpm_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rpm_q8_o    = out_rpm_q;
  assign status_o    = out_status_q;

  a_div_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on divider that is not running");

  a_zero_on_special: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ese_pkg::ST_VALID) |-> rpm_q8_o == 32'sd0)
    else $error("nonzero speed with a non-valid status");

  a_sign_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && res_status_q == ese_pkg::ST_VALID && neg_q)
      |-> (res_rpm_q[31] || res_rpm_q == 32'd0))
    else $error("negative delta gave positive speed");

endmodule
